>>> design/lpp_pkg.sv
// ----------------------------------------------------------------------------
// lpp_pkg
// shared types and constants of the linked page pool allocator
// ----------------------------------------------------------------------------
package lpp_pkg;

   localparam int PAGES    = 64;
   localparam int IDX_W    = 6;
   localparam int CNT_W    = 7;
   localparam int SIZE_W   = 21;
   localparam int BYTES_W  = 24;
   localparam int QUO_W    = 25;
   localparam int STEP_W   = 5;

   localparam logic [CNT_W-1:0]  POOL_SIZE_RESET = 7'd64;
   localparam logic [SIZE_W-1:0] PAGE_SIZE_RESET = 21'd32768;

   typedef enum logic [1:0] {
      OP_ALLOC_PAGES = 2'd0,
      OP_ALLOC_BYTES = 2'd1,
      OP_FREE_LIST   = 2'd2,
      OP_STEP_HEAD   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXCEEDS   = 2'd1,
      ST_SHORT     = 2'd2,
      ST_NOT_HEAD  = 2'd3
   } status_type;

   typedef enum logic {
      REG_POOL_SIZE = 1'b0,
      REG_PAGE_SIZE = 1'b1
   } reg_type;

   // one page record as held in the page memory
   typedef struct packed {
      logic             used;
      logic             has_next;
      logic             has_prev;
      logic [IDX_W-1:0] next;
      logic [IDX_W-1:0] tail;
      logic [CNT_W-1:0] count;
   } entry_type;

endpackage

>>> design/linked_page_pool_allocator.sv
// ----------------------------------------------------------------------------
// linked_page_pool_allocator
// pool of equal pages handed out as linked lists, one request at a time
// ----------------------------------------------------------------------------
// Every page record (used, next link, has-next, has-previous, and for list
// heads the tail and page count) lives in one 64-entry memory with registered
// read data. After reset, and after every write of the pool size register,
// a clearing pass writes one record per cycle back to free while no request
// is taken. A request takes one transaction at a time: an allocation scans the
// pages in index order at one page per cycle, after a bit-serial division
// for a byte request; a free walks its list page by page; a step reads the
// head and, if it has one, its next page. A result that finds the output
// register still occupied waits for it. A finished result waits in the output
// register while the next request is taken.
// ----------------------------------------------------------------------------
module linked_page_pool_allocator (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic [lpp_pkg::CNT_W-1:0]     req_page_total,
   input  logic [lpp_pkg::BYTES_W-1:0]   req_byte_total,
   input  logic [lpp_pkg::IDX_W-1:0]     req_head_page,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lpp_pkg::IDX_W-1:0]     rsp_first_page,
   output logic                          rsp_first_valid,
   output logic [lpp_pkg::IDX_W-1:0]     rsp_last_page,
   output logic [lpp_pkg::CNT_W-1:0]     rsp_pages_in_list,
   output logic [lpp_pkg::CNT_W-1:0]     rsp_pool_free,
   output logic [1:0]                    rsp_status,
   // configuration
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [lpp_pkg::SIZE_W-1:0]    csr_wdata
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_CHECK,
      S_SCAN,
      S_ALLOC_LAST,
      S_ALLOC_FIRST,
      S_HEAD,
      S_WALK,
      S_STEP_NX,
      S_RESULT
   } state_type;

   localparam int IW = lpp_pkg::IDX_W;
   localparam int CW = lpp_pkg::CNT_W;
   localparam int QW = lpp_pkg::QUO_W;

   // control registers
   state_type                     state_ff, state_in;
   logic [IW-1:0]                 clr_idx_ff, clr_idx_in;
   logic [CW-1:0]                 pool_size_ff, pool_size_in;
   logic [lpp_pkg::SIZE_W-1:0]    page_size_ff, page_size_in;
   logic [CW-1:0]                 free_ff, free_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          pend_ff, pend_in;

   // working registers of the current transaction
   lpp_pkg::op_type               op_ff, op_in;
   logic [QW-1:0]                 want_ff, want_in;
   lpp_pkg::status_type           status_ff, status_in;
   logic [CW-1:0]                 rd_idx_ff, rd_idx_in;
   logic [IW-1:0]                 pend_idx_ff, pend_idx_in;
   logic [CW-1:0]                 added_ff, added_in;
   logic [IW-1:0]                 first_ff, first_in;
   logic [IW-1:0]                 last_ff, last_in;
   logic [IW-1:0]                 first_next_ff, first_next_in;
   logic [IW-1:0]                 p_ff, p_in;
   logic [CW-1:0]                 freed_ff, freed_in;
   logic [IW-1:0]                 tail_ff, tail_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;

   // result being assembled, then the output register
   logic [IW-1:0]                 res_first_ff, res_first_in;
   logic                          res_valid_ff, res_valid_in;
   logic [IW-1:0]                 res_last_ff, res_last_in;
   logic [CW-1:0]                 res_cnt_ff, res_cnt_in;
   lpp_pkg::status_type           res_status_ff, res_status_in;
   logic [IW-1:0]                 out_first_ff, out_first_in;
   logic                          out_valid_ff, out_valid_in;
   logic [IW-1:0]                 out_last_ff, out_last_in;
   logic [CW-1:0]                 out_cnt_ff, out_cnt_in;
   logic [CW-1:0]                 out_free_ff, out_free_in;
   lpp_pkg::status_type           out_status_ff, out_status_in;

   // memory port
   logic                          wr_en;
   logic [IW-1:0]                 wr_addr;
   lpp_pkg::entry_type            wr_entry;
   logic [IW-1:0]                 rd_addr;
   logic [$bits(lpp_pkg::entry_type)-1:0] rd_raw;
   lpp_pkg::entry_type            rd_entry;

   // divider
   logic                          div_start;
   logic                          div_done;
   logic [QW-1:0]                 div_dividend;
   logic [lpp_pkg::SIZE_W-1:0]    div_divisor;
   logic [QW-1:0]                 div_quotient;

   // helpers
   logic [CW-1:0]                 eff_n;
   logic [CW-1:0]                 wantc;
   logic [CW-1:0]                 new_count;
   logic                          req_fire;
   logic                          found;
   logic                          nx_ok;
   logic                          out_free_slot;

   lpp_ram #(
      .WIDTH ($bits(lpp_pkg::entry_type)),
      .DEPTH (lpp_pkg::PAGES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   lpp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rd_entry = lpp_pkg::entry_type'(rd_raw);

   // pages in the pool, capped at the memory depth
   assign eff_n = (pool_size_ff > CW'(lpp_pkg::PAGES)) ? CW'(lpp_pkg::PAGES) : pool_size_ff;

   // byte request rounds up: (bytes + size - 1) / size, size 0 taken as 1
   assign div_divisor  = (page_size_ff == '0) ? lpp_pkg::SIZE_W'(1) : page_size_ff;
   assign div_dividend = QW'(req_byte_total) + QW'(div_divisor) - QW'(1);

   assign req_ready     = (state_ff == S_IDLE);
   assign req_fire      = req_valid && req_ready;
   assign out_free_slot = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      pool_size_in  = pool_size_ff;
      page_size_in  = page_size_ff;
      free_in       = free_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      pend_in       = 1'b0;
      op_in         = op_ff;
      want_in       = want_ff;
      status_in     = status_ff;
      rd_idx_in     = rd_idx_ff;
      pend_idx_in   = pend_idx_ff;
      added_in      = added_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      first_next_in = first_next_ff;
      p_in          = p_ff;
      freed_in      = freed_ff;
      tail_in       = tail_ff;
      cnt_in        = cnt_ff;
      res_first_in  = res_first_ff;
      res_valid_in  = res_valid_ff;
      res_last_in   = res_last_ff;
      res_cnt_in    = res_cnt_ff;
      res_status_in = res_status_ff;
      out_first_in  = out_first_ff;
      out_valid_in  = out_valid_ff;
      out_last_in   = out_last_ff;
      out_cnt_in    = out_cnt_ff;
      out_free_in   = out_free_ff;
      out_status_in = out_status_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_entry      = '0;
      rd_addr       = '0;
      div_start     = 1'b0;
      wantc         = '0;
      new_count     = '0;
      found         = 1'b0;
      nx_ok         = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            // one record per cycle back to free
            wr_en      = 1'b1;
            wr_addr    = clr_idx_ff;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == IW'(lpp_pkg::PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               op_in     = lpp_pkg::op_type'(req_opcode);
               p_in      = req_head_page;
               freed_in  = '0;
               status_in = lpp_pkg::ST_OK;
               unique case (lpp_pkg::op_type'(req_opcode))
                  lpp_pkg::OP_ALLOC_PAGES: begin
                     want_in  = QW'(req_page_total);
                     state_in = S_CHECK;
                  end
                  lpp_pkg::OP_ALLOC_BYTES: begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
                  lpp_pkg::OP_FREE_LIST, lpp_pkg::OP_STEP_HEAD: begin
                     rd_addr = req_head_page;
                     if ({1'b0, req_head_page} >= eff_n) begin
                        res_first_in  = '0;
                        res_valid_in  = 1'b0;
                        res_last_in   = '0;
                        res_cnt_in    = '0;
                        res_status_in = lpp_pkg::ST_NOT_HEAD;
                        state_in      = S_RESULT;
                     end else begin
                        state_in = S_HEAD;
                     end
                  end
               endcase
            end
         end

         S_DIV: begin
            if (div_done) begin
               want_in  = div_quotient;
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            res_first_in = '0;
            res_valid_in = 1'b0;
            res_last_in  = '0;
            res_cnt_in   = '0;
            if (want_ff > QW'(eff_n)) begin
               res_status_in = lpp_pkg::ST_EXCEEDS;
               state_in      = S_RESULT;
            end else begin
               // cut to the free count when short
               if (want_ff > QW'(free_ff)) begin
                  wantc     = free_ff;
                  status_in = lpp_pkg::ST_SHORT;
               end else begin
                  wantc = want_ff[CW-1:0];
               end
               want_in   = QW'(wantc);
               rd_idx_in = '0;
               added_in  = '0;
               if (wantc == '0) begin
                  res_status_in = status_in;
                  state_in      = S_RESULT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // issue the next read while the previous record comes back
            rd_addr = rd_idx_ff[IW-1:0];
            if (rd_idx_ff < eff_n) begin
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff[IW-1:0];
               rd_idx_in   = rd_idx_ff + 1'b1;
            end
            found = pend_ff && (added_ff < want_ff[CW-1:0]) && !rd_entry.used;
            if (found) begin
               if (added_ff == '0) begin
                  first_in = pend_idx_ff;
               end else begin
                  // link the previous page to this one
                  wr_en             = 1'b1;
                  wr_addr           = last_ff;
                  wr_entry.used     = 1'b1;
                  wr_entry.has_next = 1'b1;
                  wr_entry.has_prev = (last_ff != first_ff);
                  wr_entry.next     = pend_idx_ff;
                  if (added_ff == CW'(1)) begin
                     first_next_in = pend_idx_ff;
                  end
               end
               last_in  = pend_idx_ff;
               added_in = added_ff + 1'b1;
               if (added_in == want_ff[CW-1:0]) begin
                  state_in = S_ALLOC_LAST;
               end
            end else if (!(rd_idx_ff < eff_n) && !pend_ff) begin
               if (added_ff == '0) begin
                  res_first_in  = '0;
                  res_valid_in  = 1'b0;
                  res_last_in   = '0;
                  res_cnt_in    = '0;
                  res_status_in = status_ff;
                  state_in      = S_RESULT;
               end else begin
                  state_in = S_ALLOC_LAST;
               end
            end
         end

         S_ALLOC_LAST: begin
            // tail record; also the head record when the list has one page
            wr_en             = 1'b1;
            wr_addr           = last_ff;
            wr_entry.used     = 1'b1;
            wr_entry.has_prev = (added_ff != CW'(1));
            wr_entry.tail     = last_ff;
            wr_entry.count    = added_ff;
            free_in           = free_ff - added_ff;
            res_first_in      = first_ff;
            res_valid_in      = 1'b1;
            res_last_in       = last_ff;
            res_cnt_in        = added_ff;
            res_status_in     = status_ff;
            state_in          = (added_ff != CW'(1)) ? S_ALLOC_FIRST : S_RESULT;
         end

         S_ALLOC_FIRST: begin
            wr_en             = 1'b1;
            wr_addr           = first_ff;
            wr_entry.used     = 1'b1;
            wr_entry.has_next = 1'b1;
            wr_entry.next     = first_next_ff;
            wr_entry.tail     = last_ff;
            wr_entry.count    = added_ff;
            state_in          = S_RESULT;
         end

         S_HEAD, S_WALK: begin
            res_first_in  = '0;
            res_valid_in  = 1'b0;
            res_last_in   = '0;
            res_status_in = lpp_pkg::ST_OK;
            priority if (state_ff == S_HEAD && (!rd_entry.used || rd_entry.has_prev)) begin
               res_cnt_in    = '0;
               res_status_in = lpp_pkg::ST_NOT_HEAD;
               state_in      = S_RESULT;
            end else if (state_ff == S_WALK && !rd_entry.used) begin
               res_cnt_in = freed_ff;
               state_in   = S_RESULT;
            end else begin
               // give the page back
               wr_en   = 1'b1;
               wr_addr = p_ff;
               if (free_ff < eff_n) begin
                  free_in = free_ff + 1'b1;
               end
               // a link to the page just freed reads as free
               nx_ok   = rd_entry.has_next && ({1'b0, rd_entry.next} < eff_n)
                         && (rd_entry.next != p_ff);
               rd_addr = rd_entry.next;
               p_in    = rd_entry.next;
               if (op_ff == lpp_pkg::OP_FREE_LIST) begin
                  freed_in = freed_ff + 1'b1;
                  if (nx_ok && freed_in != CW'(lpp_pkg::PAGES)) begin
                     state_in = S_WALK;
                  end else begin
                     res_cnt_in = freed_in;
                     state_in   = S_RESULT;
                  end
               end else begin
                  tail_in    = rd_entry.tail;
                  cnt_in     = (rd_entry.count == '0) ? '0 : rd_entry.count - 1'b1;
                  res_cnt_in = '0;
                  state_in   = nx_ok ? S_STEP_NX : S_RESULT;
               end
            end
         end

         S_STEP_NX: begin
            res_status_in = lpp_pkg::ST_OK;
            if (!rd_entry.used) begin
               res_first_in = '0;
               res_valid_in = 1'b0;
               res_last_in  = '0;
               res_cnt_in   = '0;
            end else begin
               // next page becomes the head
               wr_en             = 1'b1;
               wr_addr           = p_ff;
               wr_entry          = rd_entry;
               wr_entry.has_prev = 1'b0;
               wr_entry.tail     = tail_ff;
               wr_entry.count    = cnt_ff;
               res_first_in      = p_ff;
               res_valid_in      = 1'b1;
               res_last_in       = tail_ff;
               res_cnt_in        = cnt_ff;
            end
            state_in = S_RESULT;
         end

         S_RESULT: begin
            if (out_free_slot) begin
               out_first_in  = res_first_ff;
               out_valid_in  = res_valid_ff;
               out_last_in   = res_last_ff;
               out_cnt_in    = res_cnt_ff;
               out_free_in   = free_ff;
               out_status_in = res_status_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // the user must write configuration only while idle; the block does not enforce it
      if (csr_we) begin
         unique case (lpp_pkg::reg_type'(csr_index))
            lpp_pkg::REG_POOL_SIZE: begin
               pool_size_in = csr_wdata[CW-1:0];
               new_count    = csr_wdata[CW-1:0];
               free_in      = (new_count > CW'(lpp_pkg::PAGES)) ?
                              CW'(lpp_pkg::PAGES) : new_count;
               clr_idx_in   = '0;
               state_in     = S_CLEAR;
            end
            lpp_pkg::REG_PAGE_SIZE: begin
               page_size_in = csr_wdata;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_idx_ff    <= '0;
         pool_size_ff  <= lpp_pkg::POOL_SIZE_RESET;
         page_size_ff  <= lpp_pkg::PAGE_SIZE_RESET;
         free_ff       <= lpp_pkg::POOL_SIZE_RESET;
         rsp_valid_ff  <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         pool_size_ff  <= pool_size_in;
         page_size_ff  <= page_size_in;
         free_ff       <= free_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_ff       <= pend_in;
      end
      op_ff         <= op_in;
      want_ff       <= want_in;
      status_ff     <= status_in;
      rd_idx_ff     <= rd_idx_in;
      pend_idx_ff   <= pend_idx_in;
      added_ff      <= added_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      first_next_ff <= first_next_in;
      p_ff          <= p_in;
      freed_ff      <= freed_in;
      tail_ff       <= tail_in;
      cnt_ff        <= cnt_in;
      res_first_ff  <= res_first_in;
      res_valid_ff  <= res_valid_in;
      res_last_ff   <= res_last_in;
      res_cnt_ff    <= res_cnt_in;
      res_status_ff <= res_status_in;
      out_first_ff  <= out_first_in;
      out_valid_ff  <= out_valid_in;
      out_last_ff   <= out_last_in;
      out_cnt_ff    <= out_cnt_in;
      out_free_ff   <= out_free_in;
      out_status_ff <= out_status_in;
   end

   // response ports straight from the output register
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_first_page    = out_first_ff;
   assign rsp_first_valid   = out_valid_ff;
   assign rsp_last_page     = out_last_ff;
   assign rsp_pages_in_list = out_cnt_ff;
   assign rsp_pool_free     = out_free_ff;
   assign rsp_status        = out_status_ff;

endmodule

>>> design/lpp_ram.sv
// ----------------------------------------------------------------------------
// lpp_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module lpp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/lpp_div.sv
// ----------------------------------------------------------------------------
// lpp_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lpp_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lpp_pkg::QUO_W-1:0]    dividend,
   input  logic [lpp_pkg::SIZE_W-1:0]   divisor,
   output logic                         done,
   output logic [lpp_pkg::QUO_W-1:0]    quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [lpp_pkg::STEP_W-1:0]    cnt_ff, cnt_in;
   logic [lpp_pkg::SIZE_W-1:0]    rem_ff, rem_in;
   logic [lpp_pkg::SIZE_W-1:0]    dsr_ff, dsr_in;
   logic [lpp_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic [lpp_pkg::SIZE_W:0]      shifted;
   logic [lpp_pkg::SIZE_W:0]      diff;
   logic                          ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[lpp_pkg::QUO_W-1]};
      ge      = shifted >= {1'b0, dsr_ff};
      diff    = shifted - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = lpp_pkg::STEP_W'(lpp_pkg::QUO_W - 1);
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[lpp_pkg::SIZE_W-1:0] : shifted[lpp_pkg::SIZE_W-1:0];
         quo_in = {quo_ff[lpp_pkg::QUO_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the linked page pool allocator
// ----------------------------------------------------------------------------
// A directed table covers the extremes and the error codes after reset. A
// randomized part then runs through several pool sizes and page sizes.
// Every request is predicted by a behavioral copy of the page pool kept in
// this bench. Results are compared field by field against the oldest
// outstanding expectation, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

   localparam int PG = lpp_pkg::PAGES;
   localparam int IW = lpp_pkg::IDX_W;
   localparam int CW = lpp_pkg::CNT_W;
   localparam int BW = lpp_pkg::BYTES_W;
   localparam int SW = lpp_pkg::SIZE_W;

   typedef struct {
      lpp_pkg::op_type       op;
      logic [CW-1:0]         pages;
      logic [BW-1:0]         bytes;
      logic [IW-1:0]         head;
   } request_type;

   typedef struct {
      logic [IW-1:0]         first;
      logic                  first_valid;
      logic [IW-1:0]         last;
      logic [CW-1:0]         in_list;
      logic [CW-1:0]         pool_free;
      lpp_pkg::status_type   status;
   } result_type;

   // one directed row: request, plus the typed-in result where fixed is set
   typedef struct {
      request_type           req;
      logic                  fixed;
      result_type            res;
   } row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_opcode;
   logic [CW-1:0]         req_page_total;
   logic [BW-1:0]         req_byte_total;
   logic [IW-1:0]         req_head_page;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [IW-1:0]         rsp_first_page;
   logic                  rsp_first_valid;
   logic [IW-1:0]         rsp_last_page;
   logic [CW-1:0]         rsp_pages_in_list;
   logic [CW-1:0]         rsp_pool_free;
   logic [1:0]            rsp_status;
   logic                  csr_we;
   logic                  csr_index;
   logic [SW-1:0]         csr_wdata;

   linked_page_pool_allocator DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_page_total    (req_page_total),
      .req_byte_total    (req_byte_total),
      .req_head_page     (req_head_page),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_first_page    (rsp_first_page),
      .rsp_first_valid   (rsp_first_valid),
      .rsp_last_page     (rsp_last_page),
      .rsp_pages_in_list (rsp_pages_in_list),
      .rsp_pool_free     (rsp_pool_free),
      .rsp_status        (rsp_status),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // pool shadow: mirrors the page records and registers of the block
   logic              pg_used     [PG];
   logic              pg_has_next [PG];
   logic              pg_has_prev [PG];
   int                pg_next     [PG];
   int                pg_tail     [PG];
   int                pg_count    [PG];
   int                spare_pages;
   int                pool_pages_reg;
   int                page_bytes_reg;

   result_type        pending_results[$];
   int                mismatches;
   logic              quiet;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard limit on run time
   initial begin
      #40_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int usable_pages();
      return (pool_pages_reg > PG) ? PG : pool_pages_reg;
   endfunction

   function automatic void clear_pool();
      for (int i = 0; i < PG; i++) begin
         pg_used[i] = 1'b0;
         pg_has_next[i] = 1'b0;
         pg_has_prev[i] = 1'b0;
         pg_next[i] = 0;
         pg_tail[i] = 0;
         pg_count[i] = 0;
      end
      spare_pages = usable_pages();
   endfunction

   function automatic void return_page(int p);
      pg_used[p] = 1'b0;
      pg_has_next[p] = 1'b0;
      pg_has_prev[p] = 1'b0;
      if (spare_pages < usable_pages())
         spare_pages++;
   endfunction

   // expected result of one request, updating the pool shadow
   function automatic result_type pool_response(request_type r);
      result_type o;
      int      n;
      longint  want;
      longint  sz;
      int      added;
      int      first;
      int      last;
      int      h;
      int      p;
      int      nx;
      int      freed;
      int      tl;
      int      c;
      logic    more;
      o = '{first: 0, first_valid: 0, last: 0, in_list: 0, pool_free: 0,
            status: lpp_pkg::ST_OK};
      n = usable_pages();
      if (r.op == lpp_pkg::OP_ALLOC_PAGES || r.op == lpp_pkg::OP_ALLOC_BYTES) begin
         if (r.op == lpp_pkg::OP_ALLOC_PAGES) begin
            want = longint'(r.pages);
         end else begin
            sz = (page_bytes_reg == 0) ? 1 : page_bytes_reg;
            want = (longint'(r.bytes) + sz - 1) / sz;
         end
         if (want > n) begin
            o.status = lpp_pkg::ST_EXCEEDS;
         end else begin
            if (want > spare_pages) begin
               want = spare_pages;
               o.status = lpp_pkg::ST_SHORT;
            end
            added = 0;
            first = 0;
            last = 0;
            for (int i = 0; i < n && added < want; i++) begin
               if (!pg_used[i]) begin
                  pg_used[i] = 1'b1;
                  pg_has_next[i] = 1'b0;
                  if (added == 0) begin
                     first = i;
                     pg_has_prev[i] = 1'b0;
                  end else begin
                     pg_next[last] = i;
                     pg_has_next[last] = 1'b1;
                     pg_has_prev[i] = 1'b1;
                  end
                  last = i;
                  added++;
                  if (spare_pages > 0)
                     spare_pages--;
               end
            end
            if (added > 0) begin
               pg_tail[first] = last;
               pg_count[first] = added;
               o.first = IW'(first);
               o.first_valid = 1'b1;
               o.last = IW'(last);
               o.in_list = CW'(added);
            end
         end
      end else begin
         h = int'(r.head);
         if (h >= n || !pg_used[h] || pg_has_prev[h]) begin
            o.status = lpp_pkg::ST_NOT_HEAD;
         end else if (r.op == lpp_pkg::OP_FREE_LIST) begin
            p = h;
            freed = 0;
            while (freed < PG) begin
               more = pg_has_next[p];
               nx = pg_next[p] % PG;
               return_page(p);
               freed++;
               if (!more || nx >= n || !pg_used[nx])
                  break;
               p = nx;
            end
            o.in_list = CW'(freed);
         end else begin
            more = pg_has_next[h];
            nx = pg_next[h] % PG;
            tl = pg_tail[h];
            c = pg_count[h];
            return_page(h);
            if (more && nx < n && pg_used[nx]) begin
               c = (c > 0) ? c - 1 : 0;
               pg_has_prev[nx] = 1'b0;
               pg_tail[nx] = tl;
               pg_count[nx] = c;
               o.first = IW'(nx);
               o.first_valid = 1'b1;
               o.last = IW'(tl);
               o.in_list = CW'(c);
            end
         end
      end
      o.pool_free = CW'(spare_pages);
      return o;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int idle_cycles();
      int roll;
      if (quiet)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side back-pressure
   int stall_left;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0)
            stall_left = idle_cycles();
      end
   end

   // response checker: compare each transaction with the oldest expectation
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response at %0t: first %0d/%0b last %0d cnt %0d st %0d",
                        $time, rsp_first_page, rsp_first_valid, rsp_last_page,
                        rsp_pages_in_list, rsp_status);
         end else begin
            want = pending_results.pop_front();
            if (rsp_first_page !== want.first || rsp_first_valid !== want.first_valid ||
                rsp_last_page !== want.last || rsp_pages_in_list !== want.in_list ||
                rsp_pool_free !== want.pool_free || rsp_status !== want.status) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at %0t: exp first %0d/%0b last %0d cnt %0d free %0d st %0d",
                           $time, want.first, want.first_valid, want.last, want.in_list,
                           want.pool_free, want.status);
                  $display("   got first %0d/%0b last %0d cnt %0d free %0d st %0d",
                           rsp_first_page, rsp_first_valid, rsp_last_page,
                           rsp_pages_in_list, rsp_pool_free, rsp_status);
               end
            end
         end
      end
   end

   // present one request and hold it until the transaction is taken
   task automatic send_request(request_type r, logic fixed, result_type typed);
      result_type predicted;
      repeat (idle_cycles()) @(negedge clock);
      @(negedge clock);
      req_valid <= 1'b1;
      req_opcode <= r.op;
      req_page_total <= r.pages;
      req_byte_total <= r.bytes;
      req_head_page <= r.head;
      do
         @(posedge clock);
      while (!req_ready);
      predicted = pool_response(r);
      pending_results.push_back(fixed ? typed : predicted);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // register write, only with nothing outstanding
   task automatic write_csr(lpp_pkg::reg_type idx, int value);
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= SW'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == lpp_pkg::REG_POOL_SIZE) begin
         pool_pages_reg = value & 'h7F;
         clear_pool();
      end else begin
         page_bytes_reg = value & 'h1FFFFF;
      end
   endtask

   // pick a random request, leaning toward well-formed list operations
   function automatic request_type random_request();
      request_type r;
      int       heads[$];
      int       n;
      int       k;
      int       sz;
      int       roll;
      n = usable_pages();
      r.op = lpp_pkg::OP_ALLOC_PAGES;
      r.pages = '0;
      r.bytes = BW'($urandom_range(0, 'hFFFFFF));
      r.head = IW'($urandom_range(0, PG - 1));
      for (int i = 0; i < n; i++)
         if (pg_used[i] && !pg_has_prev[i])
            heads.push_back(i);
      roll = $urandom_range(0, 99);
      // favor freeing when the pool runs low
      if (spare_pages < n / 4 && heads.size() > 0 && roll < 60)
         roll = 60;
      if (roll < 35) begin
         r.op = lpp_pkg::OP_ALLOC_PAGES;
         if ($urandom_range(0, 9) == 0)
            r.pages = CW'($urandom_range(0, 127));
         else
            r.pages = CW'($urandom_range(0, (n > 12) ? n / 3 : n + 1));
      end else if (roll < 50) begin
         r.op = lpp_pkg::OP_ALLOC_BYTES;
         if ($urandom_range(0, 9) != 0) begin
            sz = (page_bytes_reg == 0) ? 1 : page_bytes_reg;
            k = $urandom_range(0, (n > 12) ? n / 3 : n + 1);
            if (k == 0)
               r.bytes = '0;
            else if (longint'(k) * sz - 1 <= 'hFFFFFF)
               r.bytes = BW'(k * sz - int'($urandom_range(0, sz - 1)));
         end
      end else begin
         r.op = ($urandom_range(0, 1) == 0) ? lpp_pkg::OP_FREE_LIST : lpp_pkg::OP_STEP_HEAD;
         if (heads.size() > 0 && $urandom_range(0, 9) < 7)
            r.head = IW'(heads[$urandom_range(0, heads.size() - 1)]);
      end
      return r;
   endfunction

   row_type directed[20];

   initial begin
      int counts[8];
      int sizes[8];
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = lpp_pkg::OP_ALLOC_PAGES;
      req_page_total = '0;
      req_byte_total = '0;
      req_head_page = '0;
      csr_we = 1'b0;
      csr_index = lpp_pkg::REG_POOL_SIZE;
      csr_wdata = '0;
      mismatches = 0;
      quiet = 1'b0;
      pool_pages_reg = int'(lpp_pkg::POOL_SIZE_RESET);
      page_bytes_reg = int'(lpp_pkg::PAGE_SIZE_RESET);
      clear_pool();

      // default pool: 64 pages of 32768 bytes
      directed = '{
      '{'{lpp_pkg::OP_ALLOC_PAGES, 0, 0, 0}, 1, '{0, 0, 0, 0, 64, lpp_pkg::ST_OK}},
      '{'{lpp_pkg::OP_ALLOC_PAGES, 65, 0, 0}, 1, '{0, 0, 0, 0, 64, lpp_pkg::ST_EXCEEDS}},
      '{'{lpp_pkg::OP_ALLOC_PAGES, 127, 0, 0}, 1, '{0, 0, 0, 0, 64, lpp_pkg::ST_EXCEEDS}},
      '{'{lpp_pkg::OP_FREE_LIST, 0, 0, 63}, 1, '{0, 0, 0, 0, 64, lpp_pkg::ST_NOT_HEAD}},
      '{'{lpp_pkg::OP_STEP_HEAD, 0, 0, 0}, 1, '{0, 0, 0, 0, 64, lpp_pkg::ST_NOT_HEAD}},
      '{'{lpp_pkg::OP_ALLOC_BYTES, 0, 0, 0}, 1, '{0, 0, 0, 0, 64, lpp_pkg::ST_OK}},
      '{'{lpp_pkg::OP_ALLOC_BYTES, 0, 'hFFFFFF, 0}, 1, '{0, 0, 0, 0, 64, lpp_pkg::ST_EXCEEDS}},
      '{'{lpp_pkg::OP_ALLOC_BYTES, 0, 1, 0}, 1, '{0, 1, 0, 1, 63, lpp_pkg::ST_OK}},
      // more than free: cut to what is left
      '{'{lpp_pkg::OP_ALLOC_PAGES, 64, 0, 0}, 1, '{1, 1, 63, 63, 0, lpp_pkg::ST_SHORT}},
      '{'{lpp_pkg::OP_ALLOC_PAGES, 1, 0, 0}, 1, '{0, 0, 0, 0, 0, lpp_pkg::ST_SHORT}},
      '{'{lpp_pkg::OP_STEP_HEAD, 0, 0, 1}, 1, '{2, 1, 63, 62, 1, lpp_pkg::ST_OK}},
      '{'{lpp_pkg::OP_FREE_LIST, 0, 0, 1}, 1, '{0, 0, 0, 0, 1, lpp_pkg::ST_NOT_HEAD}},
      // page with a previous page is not a head
      '{'{lpp_pkg::OP_FREE_LIST, 0, 0, 3}, 1, '{0, 0, 0, 0, 1, lpp_pkg::ST_NOT_HEAD}},
      '{'{lpp_pkg::OP_FREE_LIST, 0, 0, 2}, 1, '{0, 0, 0, 62, 63, lpp_pkg::ST_OK}},
      '{'{lpp_pkg::OP_FREE_LIST, 0, 0, 0}, 1, '{0, 0, 0, 1, 64, lpp_pkg::ST_OK}},
      '{'{lpp_pkg::OP_ALLOC_BYTES, 0, 32769, 0}, 1, '{0, 1, 1, 2, 62, lpp_pkg::ST_OK}},
      '{'{lpp_pkg::OP_STEP_HEAD, 0, 0, 0}, 1, '{1, 1, 1, 1, 63, lpp_pkg::ST_OK}},
      // step of a single-page list empties it
      '{'{lpp_pkg::OP_STEP_HEAD, 0, 0, 1}, 1, '{0, 0, 0, 0, 64, lpp_pkg::ST_OK}},
      '{'{lpp_pkg::OP_ALLOC_PAGES, 64, 0, 0}, 1, '{0, 1, 63, 64, 0, lpp_pkg::ST_OK}},
      '{'{lpp_pkg::OP_ALLOC_BYTES, 0, 'h800000, 0}, 0, '{0, 0, 0, 0, 0, lpp_pkg::ST_OK}}
      };

      // pool size and page size per random phase, extremes included
      counts = '{1, 0, 127, 64, 9, 33, 64, 20};
      sizes  = '{1, 4096, 1048576, 0, 2097151, 0, 1, 512};
      sizes[5] = $urandom_range(1, 1048576);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         send_request(directed[i].req, directed[i].fixed, directed[i].res);

      for (int ph = 0; ph < 8; ph++) begin
         write_csr(lpp_pkg::REG_PAGE_SIZE, sizes[ph]);
         write_csr(lpp_pkg::REG_POOL_SIZE, counts[ph]);
         quiet = (ph % 3 == 2);
         repeat (160)
            send_request(random_request(), 1'b0, '{0, 0, 0, 0, 0, lpp_pkg::ST_OK});
      end
      quiet = 1'b0;

      // drain, then allow for the slowest request to finish
      fork
         begin
            while (pending_results.size() != 0)
               @(posedge clock);
         end
         begin
            repeat (200_000) @(posedge clock);
         end
      join_any
      disable fork;
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
